FILE: rtl/brb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg: shared types and constants of the byte ring buffer
// Command codes, field widths, the result record and the link structs used
// between the controller and the output queue.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STAT_W  = 11;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ   = 3'd0,
    MODE_DEQ   = 3'd1,
    MODE_PEEK  = 3'd2,
    MODE_SKIP  = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  typedef struct packed {
    logic [STAT_W-1:0] free_bytes;
    logic [STAT_W-1:0] used_bytes;
    logic              last;
    logic              status;
    logic [BYTE_W-1:0] out_byte;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

  // Space left in the output queue once this cycle's pop is counted.
  typedef struct packed {
    logic room1;  // at least one entry free
    logic room2;  // both entries free
  } qstat_t;

endpackage
`default_nettype wire

FILE: rtl/brb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ram: byte store
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/brb_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_outq: two-entry result queue
// Decouples result delivery from command processing and absorbs the RAM
// read latency so that read bytes stream at one per cycle while m_axis takes them.
// ----------------------------------------------------------------------------
module brb_outq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire brb_pkg::push_t push_i,
  output brb_pkg::qstat_t     qstat_o,
  output logic                m_valid_o,
  input  wire logic           m_ready_i,
  output brb_pkg::res_t       m_res_o
);
  import brb_pkg::*;

  res_t       ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign m_valid_o = (cnt_q != 2'd0);
  assign m_res_o   = ent_q[rd_ptr_q];
  assign pop       = m_valid_o && m_ready_i;

  assign qstat_o.room1 = (cnt_q != 2'd2) || pop;
  assign qstat_o.room2 = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i.valid;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push_i.valid} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      ent_q[wr_ptr_q] <= push_i.res;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/brb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ctrl: ring buffer controller
// Holds the indices, fill count and block state, decodes commands, writes
// enqueued bytes and sequences RAM reads for dequeue and peek.
// ----------------------------------------------------------------------------
module brb_ctrl #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned MAX_BLOCK = 64,
  parameter int unsigned IW        = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [brb_pkg::MODE_W-1:0]    mode_i,
  input  wire logic [brb_pkg::COUNT_W-1:0]   count_i,
  input  wire logic                          first_i,
  input  wire logic [brb_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire brb_pkg::qstat_t               qstat_i,
  output brb_pkg::push_t                     push_o,
  output logic                               ram_we_o,
  output logic [IW-1:0]                      ram_waddr_o,
  output logic [brb_pkg::BYTE_W-1:0]         ram_wdata_o,
  output logic                               ram_re_o,
  output logic [IW-1:0]                      ram_raddr_o,
  input  wire logic [brb_pkg::BYTE_W-1:0]    ram_rdata_i
);
  import brb_pkg::*;

  localparam int unsigned FW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (FW > COUNT_W) ? FW : COUNT_W;
  localparam int unsigned IXW  = (IW > COUNT_W) ? IW : COUNT_W;
  localparam int unsigned SW   = IXW + 1;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
    return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [STAT_W-1:0] used_of(input logic [FW-1:0] f);
    logic [31:0] e;
    e = 32'(f);
    return e[STAT_W-1:0];
  endfunction

  function automatic logic [STAT_W-1:0] free_of(input logic [FW-1:0] f);
    logic [31:0] e;
    e = 32'(DEPTH) - 32'(f);
    return e[STAT_W-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [IW-1:0]       rd_idx_q, rd_idx_d;
  logic [IW-1:0]       wr_idx_q, wr_idx_d;
  logic [FW-1:0]       fill_q, fill_d;
  logic [COUNT_W-1:0]  blk_left_q, blk_left_d;
  logic                blk_ok_q, blk_ok_d;
  logic [IW-1:0]       rd_cur_q, rd_cur_d;
  logic [COUNT_W-1:0]  rd_left_q, rd_left_d;
  logic                rd_dq_q, rd_dq_d;
  logic                rd_valid_q, rd_valid_d;
  logic                meta_last_q, meta_last_d;
  logic [STAT_W-1:0]   meta_used_q, meta_used_d;
  logic [STAT_W-1:0]   meta_free_q, meta_free_d;

  logic                accept;
  logic                rej;
  logic                count_ok;
  logic                read_ok;
  logic [CMPW-1:0]     cnt_ext;
  logic [CMPW-1:0]     fill_ext;
  logic [CMPW-1:0]     free_ext;
  logic [SW-1:0]       skip_sum;
  logic [CMPW-1:0]     skip_fill;

  assign cnt_ext  = CMPW'(count_i);
  assign fill_ext = CMPW'(fill_q);
  assign free_ext = CMPW'(FW'(DEPTH) - fill_q);
  assign count_ok = (count_i != '0) && (count_i <= COUNT_W'(MAX_BLOCK));
  assign read_ok  = count_ok && (cnt_ext <= fill_ext);
  assign skip_fill = fill_ext - cnt_ext;

  always_comb begin
    skip_sum = SW'(rd_idx_q) + SW'(count_i);
    if (skip_sum >= SW'(DEPTH)) begin
      skip_sum = skip_sum - SW'(DEPTH);
    end
  end

  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    fill_d      = fill_q;
    blk_left_d  = blk_left_q;
    blk_ok_d    = blk_ok_q;
    rd_cur_d    = rd_cur_q;
    rd_left_d   = rd_left_q;
    rd_dq_d     = rd_dq_q;
    rd_valid_d  = 1'b0;
    meta_last_d = meta_last_q;
    meta_used_d = meta_used_q;
    meta_free_d = meta_free_q;
    in_ready_o  = 1'b0;
    accept      = 1'b0;
    rej         = 1'b1;
    push_o      = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = wr_idx_q;
    ram_wdata_o = data_byte_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = rd_cur_q;

    unique case (state_q)
      ST_IDLE: begin
        // The previous read burst must have landed before a new command.
        in_ready_o = !rd_valid_q && qstat_i.room1;
        accept     = in_valid_i && in_ready_o;
        if (accept) begin
          push_o.valid = 1'b1;
          case (mode_i)
            MODE_ENQ: begin
              if (first_i) begin
                blk_ok_d   = count_ok && (cnt_ext <= free_ext);
                blk_left_d = (count_i != '0) ? count_i - 1'b1 : '0;
              end else if (blk_left_q != '0) begin
                blk_left_d = blk_left_q - 1'b1;
              end
              if ((first_i && blk_ok_d) ||
                  (!first_i && (blk_left_q != '0) && blk_ok_q)) begin
                if (fill_q != FW'(DEPTH)) begin
                  ram_we_o = 1'b1;
                  wr_idx_d = wrap_inc(wr_idx_q);
                  fill_d   = fill_q + 1'b1;
                  rej      = 1'b0;
                end
              end
            end
            MODE_DEQ, MODE_PEEK: begin
              if (read_ok) begin
                push_o.valid = 1'b0;
                state_d      = ST_READ;
                rd_cur_d     = rd_idx_q;
                rd_left_d    = count_i;
                rd_dq_d      = (mode_i == MODE_DEQ);
              end
            end
            MODE_SKIP: begin
              if (read_ok) begin
                rd_idx_d = skip_sum[IW-1:0];
                fill_d   = skip_fill[FW-1:0];
                rej      = 1'b0;
              end
            end
            MODE_CLEAR: begin
              rd_idx_d   = '0;
              wr_idx_d   = '0;
              fill_d     = '0;
              blk_left_d = '0;
              blk_ok_d   = 1'b0;
              rej        = 1'b0;
            end
            default: begin
              rej = 1'b1;
            end
          endcase
          push_o.res.out_byte   = '0;
          push_o.res.status     = rej;
          push_o.res.last       = 1'b1;
          push_o.res.used_bytes = used_of(fill_d);
          push_o.res.free_bytes = free_of(fill_d);
        end
      end
      ST_READ: begin
        // A byte landing this cycle also takes a queue entry.
        if (rd_valid_q ? qstat_i.room2 : qstat_i.room1) begin
          ram_re_o   = 1'b1;
          rd_cur_d   = wrap_inc(rd_cur_q);
          if (rd_dq_q) begin
            rd_idx_d = wrap_inc(rd_cur_q);
            fill_d   = fill_q - 1'b1;
          end
          rd_valid_d  = 1'b1;
          meta_last_d = (rd_left_q == COUNT_W'(1));
          meta_used_d = used_of(fill_d);
          meta_free_d = free_of(fill_d);
          rd_left_d   = rd_left_q - 1'b1;
          if (rd_left_q == COUNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (rd_valid_q) begin
      push_o.valid          = 1'b1;
      push_o.res.out_byte   = ram_rdata_i;
      push_o.res.status     = 1'b0;
      push_o.res.last       = meta_last_q;
      push_o.res.used_bytes = meta_used_q;
      push_o.res.free_bytes = meta_free_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      fill_q     <= '0;
      blk_left_q <= '0;
      blk_ok_q   <= 1'b0;
      rd_cur_q   <= '0;
      rd_left_q  <= '0;
      rd_dq_q    <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_idx_q   <= rd_idx_d;
      wr_idx_q   <= wr_idx_d;
      fill_q     <= fill_d;
      blk_left_q <= blk_left_d;
      blk_ok_q   <= blk_ok_d;
      rd_cur_q   <= rd_cur_d;
      rd_left_q  <= rd_left_d;
      rd_dq_q    <= rd_dq_d;
      rd_valid_q <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_last_q <= meta_last_d;
    meta_used_q <= meta_used_d;
    meta_free_q <= meta_free_d;
  end

endmodule
`default_nettype wire

FILE: rtl/byte_ring_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer: circular byte FIFO with block enqueue
// Byte store in one synchronous RAM; commands enqueue, dequeue, peek, skip
// and clear, each answered by status beats carrying the fill level.
//
//   channel  dir  tdata                                    tuser          tlast
//   s_axis   in   count[6:0] data_byte[14:7]               mode[2:0]      -
//                                                          first[3]
//   m_axis   out  out_byte[7:0] used_bytes[18:8]           status         last
//                 free_bytes[29:19]
//
// Enqueue, skip, clear and rejected commands are taken at one beat per cycle
// while the output queue has room. Dequeue and peek of n bytes stream n beats
// at one per cycle while m_axis keeps up, and hold off the input from the
// accepting cycle through the n RAM reads until the last byte has landed.
// Reset clears the indices and fill count at once; the RAM is not cleared. A
// stalled m_axis side stops RAM reads once the two-entry output queue is full,
// and s_axis is held off while that queue has no room.
// ----------------------------------------------------------------------------
module byte_ring_buffer #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned MAX_BLOCK = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // count[6:0], data_byte[14:7], zero
  input  wire logic [3:0]  s_axis_tuser,   // mode[2:0], first[3]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // out_byte, used_bytes, free_bytes, zero
  output logic             m_axis_tuser,   // status
  output logic             m_axis_tlast
);
  import brb_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);

  qstat_t          qstat;
  push_t           push;
  res_t            res;
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic            ram_re;
  logic [IW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;

  brb_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_BLOCK (MAX_BLOCK),
    .IW        (IW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser[2:0]),
    .count_i     (s_axis_tdata[6:0]),
    .first_i     (s_axis_tuser[3]),
    .data_byte_i (s_axis_tdata[14:7]),
    .qstat_i     (qstat),
    .push_o      (push),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  brb_ram #(
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  brb_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .qstat_o   (qstat),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (res)
  );

  assign m_axis_tdata = {2'b00, res.free_bytes, res.used_bytes, res.out_byte};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

`ifndef SYNTHESIS
  // Writes happen only on command beats and reads only during a burst.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("RAM read and write in the same cycle");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> qstat.room1)
    else $error("result pushed into a full output queue");

  a_level_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (11'(m_axis_tdata[18:8] + m_axis_tdata[29:19]) == 11'(DEPTH)))
    else $error("used and free bytes disagree with the depth");

  a_reject_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata[7:0] == 8'd0)))
    else $error("rejected beat carries data or is not last");
`endif

endmodule
`default_nettype wire
